@@ sv/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, request field layout and sequencer state codes.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int WIDTH  = 32;
   localparam int DATA_W = 32;
   localparam int CNT_W  = (WIDTH > 2) ? $clog2(WIDTH) : 1;

   localparam int REQ_W  = 3 * DATA_W;
   localparam int RSP_W  = DATA_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_REDUCE = 5'b00010,
      S_SQUARE = 5'b00100,
      S_MULT   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

endpackage

@@ sv/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation
// Binary square-and-multiply with a bit-serial interleaved modular multiplier.
// ----------------------------------------------------------------------------
// A zero modulus or zero exponent goes straight to the done state.
// The shared bit-serial multiplier handles one multiplier bit per cycle.
// One request is in flight at a time; the next is accepted once the sequencer
// is idle, even while the previous response still waits in its output register.
// Reset clears the sequencer and the response valid flag.
// ----------------------------------------------------------------------------
module modular_exponentiation (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: base_value[31:0], exponent[63:32], modulus[95:64].
   input  logic [modexp_pkg::REQ_W-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: result[31:0].
   output logic [modexp_pkg::RSP_W-1:0]  rsp_tdata,
   // Fields from bit 0: bad_modulus[0].
   output logic                          rsp_tuser
);

   localparam int W  = modexp_pkg::WIDTH;
   localparam int DW = modexp_pkg::DATA_W;
   localparam int CW = modexp_pkg::CNT_W;
   localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

   modexp_pkg::state_type state_ff, state_in;

   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  base_ff, base_in;
   logic [W-1:0]  mod_ff, mod_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic [W-1:0]  mult_ff, mult_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ecnt_ff, ecnt_in;
   logic          bad_ff, bad_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_bad_ff, rsp_bad_in;

   logic [W-1:0]  req_base;
   logic [W-1:0]  req_exp;
   logic [W-1:0]  req_mod;
   logic [W-1:0]  op_a;
   logic [W+1:0]  step_t;
   logic [W+1:0]  step_m;
   logic [W+1:0]  step_m2;
   logic [W-1:0]  step_r;

   assign req_base = W'(req_tdata[DW-1:0]);
   assign req_exp  = W'(req_tdata[2*DW-1:DW]);
   assign req_mod  = W'(req_tdata[3*DW-1:2*DW]);

   assign req_tready = (state_ff == modexp_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // One multiplier bit per cycle: r = (2r + bit * a) mod m, with 2r + a < 3m.
   assign op_a    = (state_ff == modexp_pkg::S_REDUCE) ? W'(1) : acc_ff;
   assign step_m  = (W + 2)'(mod_ff);
   assign step_m2 = {1'b0, mod_ff, 1'b0};
   assign step_t  = {1'b0, r_ff, 1'b0} + (mult_ff[W-1] ? (W + 2)'(op_a) : '0);

   always_comb begin
      priority if (step_t >= step_m2) begin
         step_r = W'(step_t - step_m2);
      end else if (step_t >= step_m) begin
         step_r = W'(step_t - step_m);
      end else begin
         step_r = W'(step_t);
      end
   end

   always_comb begin
      logic next_bit;
      next_bit     = 1'b0;
      state_in     = state_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      mod_in       = mod_ff;
      exp_in       = exp_ff;
      mult_in      = mult_ff;
      cnt_in       = cnt_ff;
      ecnt_in      = ecnt_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         modexp_pkg::S_IDLE: begin
            if (req_tvalid) begin
               mod_in  = req_mod;
               exp_in  = req_exp;
               mult_in = req_base;
               r_in    = '0;
               cnt_in  = CNT_LAST;
               ecnt_in = CNT_LAST;
               bad_in  = 1'b0;
               priority if (req_mod == '0) begin
                  acc_in   = '0;
                  bad_in   = 1'b1;
                  state_in = modexp_pkg::S_DONE;
               end else if (req_exp == '0) begin
                  acc_in   = W'(1);
                  state_in = modexp_pkg::S_DONE;
               end else begin
                  acc_in   = (req_mod == W'(1)) ? '0 : W'(1);
                  state_in = modexp_pkg::S_REDUCE;
               end
            end
         end
         modexp_pkg::S_REDUCE, modexp_pkg::S_SQUARE, modexp_pkg::S_MULT: begin
            r_in    = step_r;
            mult_in = mult_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               r_in   = '0;
               cnt_in = CNT_LAST;
               priority if (state_ff == modexp_pkg::S_REDUCE) begin
                  base_in  = step_r;
                  mult_in  = acc_ff;
                  state_in = modexp_pkg::S_SQUARE;
               end else if (state_ff == modexp_pkg::S_SQUARE) begin
                  acc_in = step_r;
                  if (exp_ff[W-1]) begin
                     mult_in  = base_ff;
                     state_in = modexp_pkg::S_MULT;
                  end else begin
                     next_bit = 1'b1;
                  end
               end else begin
                  acc_in   = step_r;
                  next_bit = 1'b1;
               end
            end
         end
         modexp_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DW'(acc_ff);
               rsp_bad_in   = bad_ff;
               state_in     = modexp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = modexp_pkg::S_IDLE;
         end
      endcase

      if (next_bit) begin
         exp_in = exp_ff << 1;
         if (ecnt_ff == '0) begin
            state_in = modexp_pkg::S_DONE;
         end else begin
            ecnt_in  = ecnt_ff - 1'b1;
            mult_in  = step_r;
            state_in = modexp_pkg::S_SQUARE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      mod_ff      <= mod_in;
      exp_ff      <= exp_in;
      mult_ff     <= mult_in;
      cnt_ff      <= cnt_in;
      ecnt_ff     <= ecnt_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // The partial product stays reduced while a multiplication runs.
   a_partial_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == modexp_pkg::S_REDUCE || state_ff == modexp_pkg::S_SQUARE ||
       state_ff == modexp_pkg::S_MULT) |-> (r_ff < mod_ff))
      else $error("partial product not below modulus");

   // The accumulator stays reduced while squaring and multiplying.
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == modexp_pkg::S_SQUARE || state_ff == modexp_pkg::S_MULT) |->
      (acc_ff < mod_ff))
      else $error("accumulator not below modulus");

   // A flagged modulus always comes with a zero result.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_data_ff == '0))
      else $error("bad modulus response with nonzero result");

   // A new response is only loaded from the done state.
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready) && !$past(reset)) |->
      ($past(state_ff) == modexp_pkg::S_DONE))
      else $error("response loaded outside the done state");

endmodule

@@ dv/modular_exponentiation_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends operand triples through the request stream and checks each response
// against a square-and-multiply power computed here with exact 64-bit
// products. It starts with directed corner cases and then sends random
// operands, with random gaps on the request side and random stalls on the
// response side.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

   localparam int RANDOM_COUNT = 270;
   localparam int DRAIN_CYCLES = 2100;

   typedef struct packed {
      logic [modexp_pkg::DATA_W-1:0] modulus;
      logic [modexp_pkg::DATA_W-1:0] exponent;
      logic [modexp_pkg::DATA_W-1:0] base_value;
   } operands_type;

   typedef struct packed {
      logic [modexp_pkg::DATA_W-1:0] result;
      logic                          bad_modulus;
   } power_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [modexp_pkg::REQ_W-1:0]  req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [modexp_pkg::RSP_W-1:0]  rsp_tdata;
   logic                          rsp_tuser;

   operands_type operand_queue[$];
   power_type    power_due[$];

   int  mismatches = 0;
   int  checked = 0;
   int  zero_modulus_seen = 0;
   int  zero_exponent_seen = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  offering = 1'b0;
   bit  req_burst = 1'b0;
   bit  rsp_burst = 1'b0;

   modular_exponentiation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic power_type mod_power(operands_type ops);
      power_type   p;
      logic [63:0] m;
      logic [63:0] b;
      logic [63:0] acc;
      p.result      = '0;
      p.bad_modulus = 1'b0;
      if (ops.modulus == 0) begin
         p.bad_modulus = 1'b1;
      end else if (ops.exponent == 0) begin
         p.result = 32'd1;
      end else begin
         m   = {32'd0, ops.modulus};
         b   = {32'd0, ops.base_value} % m;
         acc = 64'd1 % m;
         for (int i = modexp_pkg::DATA_W - 1; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (ops.exponent[i]) begin
               acc = (acc * b) % m;
            end
         end
         p.result = acc[modexp_pkg::DATA_W-1:0];
      end
      return p;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 12);
   endfunction

   task automatic add_request(logic [modexp_pkg::DATA_W-1:0] b,
                              logic [modexp_pkg::DATA_W-1:0] e,
                              logic [modexp_pkg::DATA_W-1:0] m);
      operands_type ops;
      ops.base_value = b;
      ops.exponent   = e;
      ops.modulus    = m;
      operand_queue.push_back(ops);
      if (m == 0) begin
         zero_modulus_seen++;
      end else if (e == 0) begin
         zero_exponent_seen++;
      end
   endtask

   // Request driver: holds each request until it is accepted, then waits out
   // a random gap before offering the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         req_gap  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            power_due.push_back(mod_power(operand_queue.pop_front()));
            offering = 1'b0;
            if ($urandom_range(0, 15) == 0) begin
               req_burst = !req_burst;
            end
            req_gap = draw_wait(req_burst);
         end
         if (!offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (operand_queue.size() != 0) begin
               req_tdata <= operand_queue[0];
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
      end
   end

   // Response monitor: checks each response against the oldest expected
   // power and stalls for a random number of cycles once a response shows up.
   always @(posedge clock) begin
      power_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = draw_wait(rsp_burst);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (power_due.size() == 0) begin
               $display("%0t: unexpected response result=%h bad_modulus=%b",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = power_due.pop_front();
               checked++;
               if (rsp_tdata !== want.result) begin
                  $display("%0t: result mismatch, expected %h, actual %h",
                           $time, want.result, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== want.bad_modulus) begin
                  $display("%0t: bad_modulus mismatch, expected %b, actual %b",
                           $time, want.bad_modulus, rsp_tuser);
                  mismatches++;
               end
            end
            if ($urandom_range(0, 15) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_stall = draw_wait(rsp_burst);
         end else if (rsp_tvalid && rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   initial begin
      logic [modexp_pkg::DATA_W-1:0] b;
      logic [modexp_pkg::DATA_W-1:0] e;
      logic [modexp_pkg::DATA_W-1:0] m;
      int                            pick;

      // Directed corner cases.
      add_request(32'd0, 32'd0, 32'd0);
      add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      add_request(32'd7, 32'd0, 32'd13);
      add_request(32'd7, 32'd0, 32'd1);
      add_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      add_request(32'd12345, 32'd99, 32'd1);
      add_request(32'd0, 32'd5, 32'd17);
      add_request(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
      add_request(32'd3, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
      add_request(32'd1000, 32'd1, 32'd7);
      add_request(32'd13, 32'd13, 32'd13);
      add_request(32'd2, 32'h8000_0000, 32'hFFFF_FFFB);
      add_request(32'd2, 32'd31, 32'h8000_0000);
      add_request(32'd3, 32'd1, 32'd2);
      add_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAB);
      add_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      add_request(32'h8000_0001, 32'd2, 32'h8000_0000);
      add_request(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'd65537);

      // Random operands, weighted toward the special cases.
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         b    = $urandom;
         e    = $urandom;
         m    = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            m = 0;
         end else if (pick < 10) begin
            e = 0;
         end else if (pick < 14) begin
            m = $urandom_range(1, 2);
         end else if (pick < 34) begin
            m = $urandom_range(3, 1000);
         end else if (pick < 40) begin
            b = m;
         end else if (pick < 46) begin
            e = $urandom_range(1, 16);
         end
         add_request(b, e, m);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (operand_queue.size() != 0 || power_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d requests had a zero modulus, %0d a zero exponent,",
               checked, zero_modulus_seen, zero_exponent_seen);
      $display("the rest full square-and-multiply runs across random gaps and stalls.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #25ms;
      $display("Timed out waiting for responses.");
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/modexp_pkg.sv
sv/modular_exponentiation.sv
dv/modular_exponentiation_tb.sv
